// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the delay line RTL.
// FDL_ASSERT is disabled while reset is asserted; FDL_ASSERT_NORST checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FDL_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDL_ASSERT(label, clk, rstn, prop, msg)
`define FDL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- hdl/fdl_pkg.sv -----
package fdl_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int LAG_W      = 12;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LAG_MAX    = (1 << LAG_W) - 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE = 2'd2;

    // Register reset values.
    localparam logic [LAG_W-1:0]  LAG_RESET    = 12'd1;
    localparam logic [FRAC_W-1:0] FRAC_RESET   = 16'd58982;
    localparam logic              INTERP_RESET = 1'b1;

    // Tap codes, in read order.
    localparam int TAP_W = 2;
    localparam logic [TAP_W-1:0] TAP_YM1 = 2'd0;
    localparam logic [TAP_W-1:0] TAP_Y0  = 2'd1;
    localparam logic [TAP_W-1:0] TAP_Y1  = 2'd2;
    localparam logic [TAP_W-1:0] TAP_Y2  = 2'd3;

    // Arithmetic widths of the cubic datapath.
    localparam int COEF_W = SAMPLE_W + 3;
    localparam int PROD_W = COEF_W + FRAC_W + 1;
    localparam int ACC_W  = 40;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Result buffer.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // One tap read as it returns from the line memory.
    typedef struct packed {
        logic                valid;
        logic [TAP_W-1:0]    tap;
        logic                fwd;
        logic [SAMPLE_W-1:0] fwd_sample;
    } tap_beat_t;

endpackage

// ----- hdl/fdl_line_mem.sv -----
module fdl_line_mem import fdl_pkg::*; #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [SAMPLE_W-1:0] wdata,
    input  logic [AW-1:0]       raddr,
    output logic [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    // One write port and one registered read port; a read of the address
    // being written returns the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/fdl_tap_seq.sv -----
`include "assert_macros.svh"

module fdl_tap_seq import fdl_pkg::*; #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_accept,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic                lag_wr,
    input  logic [LAG_W-1:0]    lag_wdata,
    output logic                seq_ready,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [SAMPLE_W-1:0] mem_wdata,
    output logic [AW-1:0]       mem_raddr,
    output tap_beat_t           tap_beat
);

    // Number of restoring steps that bring a lag below DEPTH.
    function automatic int calc_reduce_steps(input int depth);
        int n;
        n = 0;
        while ((depth << n) <= LAG_MAX) begin
            n = n + 1;
        end
        if (n == 0) begin
            n = 1;
        end
        return n;
    endfunction

    localparam int REDUCE_STEPS = calc_reduce_steps(DEPTH);
    localparam int STEP_W = (REDUCE_STEPS > 1) ? $clog2(REDUCE_STEPS) : 1;
    localparam int DIV_W  = LAG_W + 1;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    logic              clear_busy_reg;
    logic [AW-1:0]     clear_addr_reg;
    logic              reduce_busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LAG_W-1:0]  lag_rem_reg;
    logic [AW-1:0]     wr_idx_reg;
    logic              rd_busy_reg;
    logic [TAP_W-1:0]  phase_reg;
    logic [AW-1:0]     rd_addr_reg;
    tap_beat_t         beat_reg;

    logic [DIV_W-1:0]  divisor;
    logic              rem_take;
    logic [LAG_W-1:0]  lag_rem_next;
    logic [AW:0]       tap_sum;
    logic [AW-1:0]     first_tap;

    // Lag reduction: one shifted copy of DEPTH tried per cycle.
    assign divisor      = DIV_W'(DEPTH) << step_reg;
    assign rem_take     = ({1'b0, lag_rem_reg} >= divisor);
    assign lag_rem_next = rem_take ? (lag_rem_reg - divisor[LAG_W-1:0]) : lag_rem_reg;

    // First tap sits lag+1 entries behind the write pointer.
    always_comb begin
        tap_sum = {1'b0, wr_idx_reg} + (AW+1)'(DEPTH - 1) - (AW+1)'(lag_rem_reg);
        if (tap_sum >= (AW+1)'(DEPTH)) begin
            first_tap = AW'(tap_sum - (AW+1)'(DEPTH));
        end else begin
            first_tap = tap_sum[AW-1:0];
        end
    end

    // Sequencer: clearing pass, lag reduction, and four tap reads per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg  <= 1'b1;
            clear_addr_reg  <= '0;
            reduce_busy_reg <= 1'b0;
            step_reg        <= '0;
            lag_rem_reg     <= LAG_RESET;
            wr_idx_reg      <= AW'(DEPTH / 2);
            rd_busy_reg     <= 1'b0;
            phase_reg       <= TAP_YM1;
            rd_addr_reg     <= '0;
            beat_reg        <= '0;
        end else begin
            if (clear_busy_reg) begin
                clear_addr_reg <= wrap_inc(clear_addr_reg);
                if (clear_addr_reg == AW'(DEPTH - 1)) begin
                    clear_busy_reg <= 1'b0;
                end
            end

            if (lag_wr) begin
                lag_rem_reg     <= lag_wdata;
                step_reg        <= STEP_W'(REDUCE_STEPS - 1);
                reduce_busy_reg <= 1'b1;
            end else if (reduce_busy_reg) begin
                lag_rem_reg <= lag_rem_next;
                if (step_reg == '0) begin
                    reduce_busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end

            if (item_accept) begin
                wr_idx_reg  <= wrap_inc(wr_idx_reg);
                rd_busy_reg <= 1'b1;
                phase_reg   <= TAP_Y0;
                rd_addr_reg <= wrap_inc(first_tap);
            end else if (rd_busy_reg) begin
                rd_addr_reg <= wrap_inc(rd_addr_reg);
                phase_reg   <= phase_reg + 1'b1;
                if (phase_reg == TAP_Y2) begin
                    rd_busy_reg <= 1'b0;
                end
            end

            // Tag each read in a register so the tag arrives with its registered read data.
            beat_reg.valid      <= item_accept || rd_busy_reg;
            beat_reg.tap        <= item_accept ? TAP_YM1 : phase_reg;
            beat_reg.fwd        <= item_accept && (first_tap == wr_idx_reg);
            beat_reg.fwd_sample <= sample_in;
        end
    end

    // Memory port steering.
    assign mem_we    = clear_busy_reg || item_accept;
    assign mem_waddr = clear_busy_reg ? clear_addr_reg : wr_idx_reg;
    assign mem_wdata = clear_busy_reg ? '0 : sample_in;
    assign mem_raddr = rd_busy_reg ? rd_addr_reg : first_tap;

    assign seq_ready = !clear_busy_reg && !reduce_busy_reg && !rd_busy_reg;
    assign tap_beat  = beat_reg;

    `FDL_ASSERT(a_accept_when_free, aclk, aresetn, item_accept |-> seq_ready, "item taken while sequencer busy")
    `FDL_ASSERT(a_four_reads, aclk, aresetn, item_accept |=> rd_busy_reg ##3 !rd_busy_reg, "tap read burst is not four cycles")
    `FDL_ASSERT(a_ptr_range, aclk, aresetn, {1'b0, wr_idx_reg} < (AW+1)'(DEPTH), "write pointer out of range")

endmodule

// ----- hdl/fdl_cubic.sv -----
`include "assert_macros.svh"

module fdl_cubic import fdl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  tap_beat_t           tap_beat,
    input  logic [SAMPLE_W-1:0] rdata,
    input  logic [FRAC_W-1:0]   frac,
    input  logic                interpolate,
    output logic                res_valid,
    output logic [SAMPLE_W-1:0] res_sample
);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(SAMPLE_MIN);

    logic signed [SAMPLE_W-1:0] tap_val;
    logic signed [SAMPLE_W-1:0] ym1_reg, y0_reg, y1_reg, y2_reg;
    logic                       taps_ready_reg, s1_valid_reg, s2_valid_reg;
    logic                       s3_valid_reg, s4_valid_reg, res_valid_reg;

    logic [2*FRAC_W-1:0]        a2_prod, a3_prod;
    logic [FRAC_W-1:0]          a2_reg, a3_reg;

    logic signed [COEF_W-1:0]   c3_reg, c2_reg, c1_reg;
    logic signed [SAMPLE_W-1:0] y0_s1_reg, y0_s2_reg, y0_s3_reg, y0_s4_reg;
    logic signed [PROD_W-1:0]   p3_reg, p2_reg, p1_reg;
    logic signed [ACC_W-1:0]    sum_hi_reg, sum_lo_reg, acc_reg;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic [SAMPLE_W-1:0]        res_reg;

    // The tap read in the write cycle of the same address takes the new sample.
    assign tap_val = tap_beat.fwd ? $signed(tap_beat.fwd_sample) : $signed(rdata);

    always_ff @(posedge aclk) begin
        if (tap_beat.valid) begin
            case (tap_beat.tap)
                TAP_YM1: ym1_reg <= tap_val;
                TAP_Y0:  y0_reg  <= tap_val;
                TAP_Y1:  y1_reg  <= tap_val;
                TAP_Y2:  y2_reg  <= tap_val;
                default: ;
            endcase
        end
    end

    // Powers of the fraction are registered: a2 from frac, then a3 from a2 and frac.
    assign a2_prod = frac * frac;
    assign a3_prod = a2_reg * frac;

    always_ff @(posedge aclk) begin
        a2_reg <= a2_prod[2*FRAC_W-1:FRAC_W];
        a3_reg <= a3_prod[2*FRAC_W-1:FRAC_W];
    end

    // Datapath stages: coefficients, products, partial sums, total, and round or pass-through of y0.
    always_ff @(posedge aclk) begin
        c3_reg    <= COEF_W'(y0_reg) - COEF_W'(y1_reg) + COEF_W'(y2_reg) - COEF_W'(ym1_reg);
        c2_reg    <= COEF_W'(ym1_reg) + COEF_W'(ym1_reg) - COEF_W'(y0_reg) - COEF_W'(y0_reg)
                   + COEF_W'(y1_reg) - COEF_W'(y2_reg);
        c1_reg    <= COEF_W'(y1_reg) - COEF_W'(ym1_reg);
        y0_s1_reg <= y0_reg;

        p3_reg    <= c3_reg * $signed({1'b0, a3_reg});
        p2_reg    <= c2_reg * $signed({1'b0, a2_reg});
        p1_reg    <= c1_reg * $signed({1'b0, frac});
        y0_s2_reg <= y0_s1_reg;

        sum_hi_reg <= ACC_W'(p3_reg) + ACC_W'(p2_reg);
        sum_lo_reg <= ACC_W'(p1_reg) + (ACC_W'(y0_s2_reg) <<< FRAC_W) + ROUND_BIAS;
        y0_s3_reg  <= y0_s2_reg;

        acc_reg   <= sum_hi_reg + sum_lo_reg;
        y0_s4_reg <= y0_s3_reg;

        res_reg <= interpolate ? sat_val : y0_s4_reg;
    end

    // Floor shift and saturation to the sample range.
    always_comb begin
        shifted = acc_reg >>> FRAC_W;
        if (shifted > SAT_HI) begin
            sat_val = SAMPLE_MAX;
        end else if (shifted < SAT_LO) begin
            sat_val = SAMPLE_MIN;
        end else begin
            sat_val = shifted[SAMPLE_W-1:0];
        end
    end

    // Valid chain alongside the datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_ready_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            taps_ready_reg <= tap_beat.valid && (tap_beat.tap == TAP_Y2);
            s1_valid_reg   <= taps_ready_reg;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            res_valid_reg  <= s4_valid_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_sample = res_reg;

    `FDL_ASSERT(a_result_after_taps, aclk, aresetn, taps_ready_reg |-> ##5 res_valid_reg, "late result")

endmodule

// ----- hdl/fdl_out_buf.sv -----
`include "assert_macros.svh"

module fdl_out_buf import fdl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    input  logic [SAMPLE_W-1:0] wr_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata
);

    logic [SAMPLE_W-1:0]  buf_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    logic                 pop;

    assign pop = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (wr_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Result storage; the upstream credit count keeps it from overflowing.
    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            buf_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = buf_mem[rd_ptr_reg];

    `FDL_ASSERT(a_no_overflow, aclk, aresetn, wr_valid |-> (count_reg != OUT_CNT_W'(OUT_DEPTH)), "result buffer overflow")

endmodule

// ----- hdl/fractional_delay_line_core.sv -----
// Each accepted sample starts four tap reads; the taps then pass the cubic
// datapath registers and the result buffer before m_tvalid rises. A new sample
// waits for the four tap reads of the last one through the line memory's
// single read port. Reset: registers return to lag 1, fraction 58982 and
// interpolation on; the line memory is then zeroed with s_tready low. A lag
// write holds s_tready low while the lag is reduced modulo DEPTH.
`include "assert_macros.svh"

module fractional_delay_line_core import fdl_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);

    logic                 s_accept, m_deliver, cfg_write, lag_wr, seq_ready;
    logic [FRAC_W-1:0]    frac_reg;
    logic                 interp_reg;
    logic [OUT_CNT_W-1:0] inflight_reg, inflight_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [SAMPLE_W-1:0]  mem_wdata, mem_rdata;
    tap_beat_t            tap_beat;
    logic                 res_valid;
    logic [SAMPLE_W-1:0]  res_sample;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign lag_wr    = cfg_write && (cfg_index == CFG_DELAY_LAG);
    assign s_accept  = s_tvalid && s_tready;
    assign m_deliver = m_tvalid && m_tready;

    // Fraction and mode registers; the lag lives in the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg   <= FRAC_RESET;
            interp_reg <= INTERP_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_DELAY_LAG:   ;
                CFG_FRAC:        frac_reg   <= cfg_data[FRAC_W-1:0];
                CFG_INTERPOLATE: interp_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Samples accepted and not yet delivered; bounded by the buffer depth.
    always_comb begin
        inflight_next = inflight_reg;
        if (s_accept && !m_deliver) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (!s_accept && m_deliver) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    assign s_tready = seq_ready && (inflight_reg < OUT_CNT_W'(OUT_DEPTH));

    fdl_tap_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (s_accept),
        .sample_in   (s_tdata),
        .lag_wr      (lag_wr),
        .lag_wdata   (cfg_data[LAG_W-1:0]),
        .seq_ready   (seq_ready),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .tap_beat    (tap_beat)
    );

    fdl_line_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fdl_cubic u_cubic (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tap_beat    (tap_beat),
        .rdata       (mem_rdata),
        .frac        (frac_reg),
        .interpolate (interp_reg),
        .res_valid   (res_valid),
        .res_sample  (res_sample)
    );

    fdl_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res_sample),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `FDL_ASSERT(a_inflight_bound, aclk, aresetn, inflight_reg <= OUT_CNT_W'(OUT_DEPTH), "too many samples in flight")
    `FDL_ASSERT(a_output_owed, aclk, aresetn, m_tvalid |-> (inflight_reg != '0), "result beat with nothing owed")

endmodule
